// ===== rtl/bgrcc_pkg.sv =====
// Package for the 15-bit pixel color converter: codes, weights, gamma curve and channel helpers.
`default_nettype none

package bgrcc_pkg;

  localparam int PIX_IN_W  = 15;
  localparam int PIX_OUT_W = 24;

  // configuration register indexes
  localparam logic [1:0] REG_CURVE  = 2'd0;
  localparam logic [1:0] REG_ADJUST = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;

  typedef enum logic [1:0] {
    ADJ_NONE = 2'd0,
    ADJ_GRAY = 2'd1,
    ADJ_Q332 = 2'd2,
    ADJ_Q333 = 2'd3
  } adjust_t;

  typedef enum logic [1:0] {
    FMT_555 = 2'd0,
    FMT_565 = 2'd1,
    FMT_888 = 2'd2
  } format_t;

  // Q16 luminance weights, sum is 65536
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam logic [7:0] CURVE_LUT [32] = '{
    8'h00, 8'h01, 8'h03, 8'h06, 8'h0a, 8'h0f, 8'h15, 8'h1c,
    8'h24, 8'h2d, 8'h37, 8'h42, 8'h4e, 8'h5b, 8'h69, 8'h78,
    8'h88, 8'h90, 8'h98, 8'ha0, 8'ha8, 8'hb0, 8'hb8, 8'hc0,
    8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8, 8'hff
  };

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [7:0] rep3(input logic [7:0] c);
    return {c[7:5], c[7:5], c[7:6]};
  endfunction

  function automatic logic [7:0] rep2(input logic [7:0] c);
    return {c[7:6], c[7:6], c[7:6], c[7:6]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bgr555_pixel_color_converter.sv =====
// Top level of the 15-bit pixel color converter: widen, curve, adjust and pack.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata[14:0] pixel_in
//   m_*      out  m_tvalid/m_tready    m_tdata[23:0] pixel_out
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per clock unless m_tready stalls; staged in the product and result registers.
// The luminance multiplies sit in the first stage, the sum and packing in the second.
// Synchronous reset clears both valid flags and loads the register defaults.
// A stall on m_tready holds the result; the first stage keeps filling while it is empty.
// cfg_ready is always high.
`default_nettype none

module bgr555_pixel_color_converter
  import bgrcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [14:0] pixel_in, [15] zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [23:0] pixel_out
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [1:0]  cfg_data
);

  logic    curve_enable;
  adjust_t adjust_mode;
  format_t output_format;

  logic        a_valid;
  logic [7:0]  a_r, a_g, a_b;
  logic [23:0] a_pr, a_pg, a_pb;

  logic [7:0]  c_r, c_g, c_b;
  logic [23:0] p_r, p_g, p_b;
  logic [23:0] lum_sum;
  logic [7:0]  q_r, q_g, q_b;
  logic [23:0] pack;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_enable  <= 1'b0;
      adjust_mode   <= ADJ_NONE;
      output_format <= FMT_565;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CURVE:  curve_enable  <= cfg_data[0];
        REG_ADJUST: adjust_mode   <= adjust_t'(cfg_data);
        REG_FORMAT: output_format <= format_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // widen or curve, then weight each channel
  always_comb begin
    if (curve_enable) begin
      c_r = CURVE_LUT[s_tdata[4:0]];
      c_g = CURVE_LUT[s_tdata[9:5]];
      c_b = CURVE_LUT[s_tdata[14:10]];
    end else begin
      c_r = widen5(s_tdata[4:0]);
      c_g = widen5(s_tdata[9:5]);
      c_b = widen5(s_tdata[14:10]);
    end
    p_r = {16'd0, c_r} * {8'd0, W_RED};
    p_g = {16'd0, c_g} * {8'd0, W_GREEN};
    p_b = {16'd0, c_b} * {8'd0, W_BLUE};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      a_r  <= c_r;
      a_g  <= c_g;
      a_b  <= c_b;
      a_pr <= p_r;
      a_pg <= p_g;
      a_pb <= p_b;
    end
  end

  // adjust and pack
  always_comb begin
    lum_sum = a_pr + a_pg + a_pb;
    case (adjust_mode)
      ADJ_GRAY: begin
        q_r = lum_sum[23:16];
        q_g = lum_sum[23:16];
        q_b = lum_sum[23:16];
      end
      ADJ_Q332: begin
        q_r = rep3(a_r);
        q_g = rep3(a_g);
        q_b = rep2(a_b);
      end
      ADJ_Q333: begin
        q_r = rep3(a_r);
        q_g = rep3(a_g);
        q_b = rep3(a_b);
      end
      default: begin
        q_r = a_r;
        q_g = a_g;
        q_b = a_b;
      end
    endcase
    case (output_format)
      FMT_555: pack = {9'd0, q_r[7:3], q_g[7:3], q_b[7:3]};
      FMT_565: pack = {8'd0, q_r[7:3], q_g[7:2], q_b[7:3]};
      default: pack = {q_r, q_g, q_b};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= a_valid;
    end
    if (advance && a_valid) begin
      m_tdata <= pack;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bgrcc_checker.sv =====
// Port checker for the 15-bit pixel color converter, bound to the top level.
`default_nettype none

module bgrcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input blocked while output drains");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tready ##1 m_tready) |=> m_tvalid)
    else $error("beat did not reach output in two cycles");

endmodule

bind bgr555_pixel_color_converter bgrcc_checker u_bgrcc_checker (.*);

`default_nettype wire
